>>> hdl/merge_sort_engine_defines.svh
// Assertion macros shared by the merge sort engine modules
`ifndef MERGE_SORT_ENGINE_DEFINES_SVH
`define MERGE_SORT_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MSE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MSE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSE_ASSERT(label, clk, rst, prop, msg)
`define MSE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> hdl/mse_pkg.sv
// Types and constants of the merge sort engine
package mse_pkg;
   localparam int ValueWidth = 32;
   typedef logic signed [ValueWidth-1:0] value_type;
   // request as queued between front and back
   typedef struct packed {
      value_type value;
      logic      last;
   } req_item_type;
   // result item
   typedef struct packed {
      value_type sorted_value;
      logic      final_res;
      logic      overflowed;
   } rsp_item_type;
endpackage

>>> hdl/mse_req_if.sv
// Request channel interface
interface mse_req_if import mse_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type value;
   logic      last;
   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);
endinterface

>>> hdl/mse_rsp_if.sv
// Result channel interface
interface mse_rsp_if import mse_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type sorted_value;
   logic      final_res;
   logic      overflowed;
   modport source (output valid, output sorted_value, output final_res, output overflowed,
                   input ready);
   modport sink (input valid, input sorted_value, input final_res, input overflowed,
                 output ready);
endinterface

>>> hdl/merge_sort_engine.sv
// Top level of the merge sort engine
//  channel | direction | payload
//  req     | in        | value[31:0] signed, last
//  rsp     | out       | sorted_value[31:0] signed, final_res, overflowed
// Loading stores one request per cycle while the queue offers one; a closed batch
// of n values is merged in ceil(log2 n) passes through one shared merge unit
// that ping-pongs between two RAMs, then emitted one value at a time while the
// receiver is ready.
// Reset is synchronous and clears control state only; RAMs need no clearing.
// The request queue lets the front accept up to two requests while the back sorts or stalls.
module merge_sort_engine import mse_pkg::*; #(
   parameter int MAX_ELEMENTS = 64
) (
   input logic        clock,
   input logic        reset,
   mse_req_if.sink    req,
   mse_rsp_if.source  rsp
);
   logic         q_full, q_push, q_pop, q_ne;
   req_item_type q_in, q_out;

   mse_front u_front (.clock(clock), .reset(reset), .req(req), .q_full(q_full),
                      .q_push(q_push), .q_data(q_in));
   mse_queue #(.Depth(2)) u_queue (.clock(clock), .reset(reset), .push(q_push),
      .push_data(q_in), .full(q_full), .pop(q_pop), .pop_data(q_out), .not_empty(q_ne));
   mse_back #(.MaxElements(MAX_ELEMENTS)) u_back (.clock(clock), .reset(reset),
      .q_valid(q_ne), .q_data(q_out), .q_pop(q_pop), .rsp(rsp));
endmodule

>>> hdl/mse_ram.sv
// Generic single write port, single read port RAM with registered read
module mse_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

>>> hdl/mse_queue.sv
// Short request queue between the front and back parts
module mse_queue import mse_pkg::*; #(
   parameter int Depth = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  req_item_type push_data,
   output logic         full,
   input  logic         pop,
   output req_item_type pop_data,
   output logic         not_empty
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   req_item_type       slot_ff [Depth];
   logic [AW-1:0]      wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]        cnt_ff, cnt_in;

   assign full      = (cnt_ff == (AW+1)'(Depth));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = slot_ff[rp_ff];

   // advance pointers
   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == AW'(Depth-1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == AW'(Depth-1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= push_data;
      end
   end
endmodule

>>> hdl/mse_front.sv
// Front part: accept requests and pass them into the queue
module mse_front import mse_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   mse_req_if.sink       req,
   input  logic          q_full,
   output logic          q_push,
   output req_item_type  q_data
);
   `include "merge_sort_engine_defines.svh"

   assign req.ready    = !q_full;
   assign q_push       = req.valid && !q_full;
   assign q_data.value = req.value;
   assign q_data.last  = req.last;

   `MSE_ASSERT(a_no_push_full, clock, reset, q_full |-> !q_push, "push into full queue")
   `MSE_ASSERT(a_push_handshake, clock, reset, q_push == (req.valid && req.ready), "push mismatch")
   `MSE_ASSERT(a_ready_full, clock, reset, req.ready != q_full, "ready disagrees with queue")
endmodule

>>> hdl/mse_back.sv
// Back part: store the batch, merge sort it between two RAMs, emit results
module mse_back import mse_pkg::*; #(
   parameter int MaxElements = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  req_item_type  q_data,
   output logic          q_pop,
   mse_rsp_if.source     rsp
);
   `include "merge_sort_engine_defines.svh"

   localparam int AW = $clog2(MaxElements);
   localparam int CW = AW + 1;

   typedef enum logic [6:0] {
      ST_LOAD  = 7'b0000001,
      ST_PASS  = 7'b0000010,
      ST_RDL   = 7'b0000100,
      ST_RDR   = 7'b0001000,
      ST_CMP   = 7'b0010000,
      ST_EMRD  = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   state_type      st_ff, st_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           ovf_ff, ovf_in;
   logic           src_ff, src_in;       // which RAM holds the current runs
   logic [CW-1:0]  wid_ff, wid_in;
   logic [CW-1:0]  lo_ff, lo_in;
   logic [CW-1:0]  l_ff, l_in, r_ff, r_in, k_ff, k_in, mid_ff, mid_in, hi_ff, hi_in;
   value_type      lv_ff, lv_in;
   logic           rsp_v_ff, rsp_v_in;
   rsp_item_type   rsp_ff, rsp_in;

   // RAM ports
   logic           we0, we1;
   logic [AW-1:0]  wa, ra;
   value_type      wd, rd0, rd1, rdat;

   mse_ram #(.Width(ValueWidth), .Depth(MaxElements)) u_ram0 (
      .clock(clock), .wr_en(we0), .wr_addr(wa), .wr_data(wd), .rd_addr(ra), .rd_data(rd0));
   mse_ram #(.Width(ValueWidth), .Depth(MaxElements)) u_ram1 (
      .clock(clock), .wr_en(we1), .wr_addr(wa), .wr_data(wd), .rd_addr(ra), .rd_data(rd1));

   assign rdat = src_ff ? rd1 : rd0;
   assign rsp.valid        = rsp_v_ff;
   assign rsp.sorted_value = rsp_ff.sorted_value;
   assign rsp.final_res    = rsp_ff.final_res;
   assign rsp.overflowed   = rsp_ff.overflowed;

   logic [CW:0] mid_w, hi_w;
   logic        take_l, l_live, r_live;

   // sequence load, merge passes and emission
   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; ovf_in = ovf_ff; src_in = src_ff;
      wid_in = wid_ff; lo_in = lo_ff; l_in = l_ff; r_in = r_ff; k_in = k_ff;
      mid_in = mid_ff; hi_in = hi_ff; lv_in = lv_ff;
      rsp_v_in = rsp_v_ff && !rsp.ready; rsp_in = rsp_ff;
      q_pop = 1'b0; we0 = 1'b0; we1 = 1'b0; wa = '0; wd = q_data.value; ra = '0;
      mid_w = {1'b0, lo_ff} + {1'b0, wid_ff};
      hi_w  = mid_w + {1'b0, wid_ff};
      l_live = (l_ff < mid_ff);
      r_live = (r_ff < hi_ff);
      // left run wins ties; right value arrives from the RAM in the compare cycle
      take_l = l_live && (!r_live || (lv_ff <= rdat));
      case (st_ff)
         ST_LOAD: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (cnt_ff < CW'(MaxElements)) begin
                  we0 = 1'b1; wa = cnt_ff[AW-1:0]; cnt_in = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (q_data.last) begin
                  src_in = 1'b0; wid_in = CW'(1); lo_in = '0; st_in = ST_PASS;
               end
            end
         end
         ST_PASS: begin
            // start next merge of a run pair, or next pass, or emission
            if (wid_ff >= cnt_ff) begin
               k_in = '0; st_in = ST_EMRD;
            end else if (mid_w >= {1'b0, cnt_ff}) begin
               // copy tail run unchanged into the other RAM
               l_in = lo_ff; mid_in = cnt_ff; r_in = cnt_ff; hi_in = cnt_ff;
               k_in = lo_ff; st_in = ST_RDL;
            end else begin
               l_in = lo_ff; mid_in = mid_w[CW-1:0]; r_in = mid_w[CW-1:0];
               hi_in = (hi_w > {1'b0, cnt_ff}) ? cnt_ff : hi_w[CW-1:0];
               k_in = lo_ff; st_in = ST_RDL;
            end
         end
         ST_RDL: begin
            ra = l_ff[AW-1:0]; st_in = ST_RDR;
         end
         ST_RDR: begin
            ra = r_ff[AW-1:0]; lv_in = rdat; st_in = ST_CMP;
         end
         ST_CMP: begin
            if (!l_live && !r_live) begin
               // run pair done
               if (hi_w >= {1'b0, cnt_ff} || mid_w >= {1'b0, cnt_ff}) begin
                  src_in = !src_ff; wid_in = {wid_ff[CW-2:0], 1'b0}; lo_in = '0;
               end else begin
                  lo_in = hi_w[CW-1:0];
               end
               st_in = ST_PASS;
            end else begin
               // write the smaller head into the other RAM
               wa = k_ff[AW-1:0];
               wd = take_l ? lv_ff : rdat;
               we0 = src_ff; we1 = !src_ff;
               k_in = k_ff + 1'b1;
               if (take_l) begin
                  l_in = l_ff + 1'b1;
               end else begin
                  r_in = r_ff + 1'b1;
               end
               st_in = ST_RDL;
            end
         end
         ST_EMRD: begin
            ra = k_ff[AW-1:0];
            if (!rsp_v_ff || rsp.ready) begin
               st_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            ra = k_ff[AW-1:0];
            rsp_v_in = 1'b1;
            rsp_in.sorted_value = rdat;
            rsp_in.final_res = (k_ff + 1'b1 == cnt_ff);
            rsp_in.overflowed = ovf_ff;
            k_in = k_ff + 1'b1;
            if (k_ff + 1'b1 == cnt_ff) begin
               cnt_in = '0; ovf_in = 1'b0; st_in = ST_LOAD;
            end else begin
               st_in = ST_EMRD;
            end
         end
         default: st_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_LOAD; cnt_ff <= '0; ovf_ff <= 1'b0; rsp_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; ovf_ff <= ovf_in; rsp_v_ff <= rsp_v_in;
      end
      src_ff <= src_in; wid_ff <= wid_in; lo_ff <= lo_in; l_ff <= l_in; r_ff <= r_in;
      k_ff <= k_in; mid_ff <= mid_in; hi_ff <= hi_in; lv_ff <= lv_in;
      rsp_ff <= rsp_in;
   end

   `MSE_ASSERT(a_cnt_cap, clock, reset, cnt_ff <= CW'(MaxElements), "count beyond capacity")
   `MSE_ASSERT(a_pop_load, clock, reset, q_pop |-> (st_ff == ST_LOAD), "pop outside load")
   `MSE_ASSERT(a_emit_slot, clock, reset, (st_ff == ST_EMIT) |=> rsp_v_ff, "emit lost")
   `MSE_ASSERT(a_emit_free, clock, reset, (st_ff == ST_EMIT) |-> !rsp_v_ff, "emit over result")
endmodule

>>> sim/merge_sort_engine_tb.sv
// Testbench for the merge sort engine: batch stimulus, sorted-result prediction and checks
module merge_sort_engine_tb;
   import mse_pkg::*;

   localparam int Capacity = 64;
   localparam int WatchdogLimit = 200000;

   logic clock;
   logic reset;

   mse_req_if req_ch ();
   mse_rsp_if rsp_ch ();

   merge_sort_engine #(.MAX_ELEMENTS(Capacity)) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   // predictor state: values of the open batch and its drop flag
   value_type batch_values[$];
   logic batch_dropped;
   rsp_item_type sorted_expected[$];

   int send_idle_pct;
   int recv_idle_pct;
   bit recv_hold;
   int fail_count = 0;
   int req_count;
   int rsp_count = 0;
   int batch_count;
   int idle_cycles;

   // clock generation
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // stable merge: left run wins ties
   function automatic void predict_batch();
      value_type src[$];
      value_type dst[$];
      int n, w, lo, mid, hi, l, r;
      src = batch_values;
      n = src.size();
      for (w = 1; w < n; w = w * 2) begin
         dst = src;
         for (lo = 0; lo < n; lo = lo + 2 * w) begin
            mid = lo + w;
            if (mid >= n) break;
            hi = (mid + w > n) ? n : mid + w;
            l = lo;
            r = mid;
            for (int k = lo; k < hi; k++) begin
               if (r >= hi || (l < mid && src[l] <= src[r])) begin
                  dst[k] = src[l];
                  l++;
               end else begin
                  dst[k] = src[r];
                  r++;
               end
            end
         end
         src = dst;
      end
      for (int i = 0; i < n; i++) begin
         sorted_expected.push_back('{sorted_value: src[i], final_res: (i == n - 1),
                                     overflowed: batch_dropped});
      end
      batch_values.delete();
      batch_dropped = 1'b0;
   endfunction

   // send one request, then update the prediction; valid stays high until the next
   // call either idles or offers the next request
   task automatic send_value(input value_type v, input logic lst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= v;
      req_ch.last <= lst;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      req_count++;
      if (batch_values.size() < Capacity) batch_values.push_back(v);
      else batch_dropped = 1'b1;
      if (lst) begin
         predict_batch();
         batch_count++;
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sorted_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic value_type rand_value();
      case ($urandom_range(5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return value_type'($urandom_range(7)) - 3;
         default: return value_type'($urandom);
      endcase
   endfunction

   task automatic send_batch(input int n);
      for (int i = 0; i < n; i++) send_value(rand_value(), i == n - 1);
   endtask

   // receiver ready, with random stalls and the long hold-off
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      rsp_item_type exp_item;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_count++;
         if (sorted_expected.size() == 0) begin
            $error("unexpected result value %0d", rsp_ch.sorted_value);
            fail_count++;
         end else begin
            exp_item = sorted_expected.pop_front();
            if (rsp_ch.sorted_value !== exp_item.sorted_value) begin
               $error("sorted_value expected %0d actual %0d", exp_item.sorted_value,
                      rsp_ch.sorted_value);
               fail_count++;
            end
            if (rsp_ch.final_res !== exp_item.final_res) begin
               $error("final_res expected %0b actual %0b", exp_item.final_res,
                      rsp_ch.final_res);
               fail_count++;
            end
            if (rsp_ch.overflowed !== exp_item.overflowed) begin
               $error("overflowed expected %0b actual %0b", exp_item.overflowed,
                      rsp_ch.overflowed);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("watchdog expired");
         $display("simulation failed");
         $finish;
      end
   end

   task automatic test_directed();
      value_type v;
      send_value(32'sd5, 1'b1);
      send_value(32'sh7fffffff, 1'b0);
      send_value(32'sh80000000, 1'b0);
      send_value(32'sd0, 1'b0);
      send_value(-32'sd1, 1'b0);
      send_value(32'sd0, 1'b1);
      send_value(32'sd3, 1'b0);
      send_value(32'sd3, 1'b0);
      send_value(32'sd3, 1'b1);
      // all ones and alternating bit patterns
      send_value(32'shffffffff, 1'b0);
      send_value(32'sh55555555, 1'b0);
      send_value(32'shaaaaaaaa, 1'b0);
      send_value(32'sh00000001, 1'b1);
      v = 32'sh12345678;
      send_value(v, 1'b0);
      send_value(~v, 1'b1);
      wait_drained();
   endtask

   task automatic test_overflow();
      // fill one batch exactly, then overflow a second batch with plain and closing dropped items
      send_batch(Capacity);
      for (int i = 0; i < Capacity + 2; i++) send_value(rand_value(), 1'b0);
      send_value(32'sh7fffffff, 1'b1);
      wait_drained();
   endtask

   task automatic test_backpressure();
      // hold the receiver while the sender keeps offering
      recv_hold = 1'b1;
      fork
         begin
            repeat (1500) @(posedge clock);
            recv_hold = 1'b0;
         end
         begin
            for (int b = 0; b < 6; b++) send_batch($urandom_range(2, 12));
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      join
      wait_drained();
   endtask

   task automatic test_random(input int s_pct, input int r_pct, input int items);
      int sent;
      int n;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      sent = 0;
      while (sent < items) begin
         n = ($urandom_range(15) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 8);
         send_batch(n);
         sent += n;
      end
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      req_ch.last = 1'b0;
      recv_hold = 1'b0;
      batch_dropped = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      req_count = 0;
      batch_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_overflow();
      test_backpressure();
      test_random(15, 84, 40);
      test_random(84, 15, 40);
      test_random(0, 0, 100);

      repeat (200) @(posedge clock);
      $display("covered %0d requests in %0d batches, %0d sorted results checked",
               req_count, batch_count, rsp_count);
      $display("includes single-value, tie, extreme and overflowed batches");
      if (fail_count == 0 && sorted_expected.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

>>> sim.f
+incdir+hdl
hdl/mse_pkg.sv
hdl/mse_req_if.sv
hdl/mse_rsp_if.sv
hdl/mse_ram.sv
hdl/mse_queue.sv
hdl/mse_front.sv
hdl/mse_back.sv
hdl/merge_sort_engine.sv
sim/merge_sort_engine_tb.sv
